// ===== design/pfcib_pkg.sv =====
// Shared types and constants for the PFC ingress buffer admission block.
package pfcib_pkg;

	localparam int BYTE_W  = 26;
	localparam int RSV_W   = 20;
	localparam int SHIFT_W = 5;
	localparam int PORTS_W = 7;
	localparam int PKT_W   = 16;
	localparam int SIZE_W  = 16;
	localparam int PORT_W  = 6;
	localparam int QIDX_W  = 3;
	localparam int CIDX_W  = 3;
	localparam int SETA_W  = PORTS_W + RSV_W + 1;
	localparam int USED_W  = SETA_W + 1;

	localparam logic [BYTE_W-1:0] BYTE_MAX = '1;
	localparam logic [PKT_W-1:0]  PKT_MAX  = '1;

	localparam logic [BYTE_W-1:0] RST_BUFFER  = BYTE_W'(12 * 1024 * 1024);
	localparam logic [RSV_W-1:0]  RST_RESERVE = RSV_W'(4 * 1024);
	localparam logic [RSV_W-1:0]  RST_RESUME  = RSV_W'(3 * 1024);

	typedef enum logic [CIDX_W-1:0] {
		REG_BUFFER       = 3'd0,
		REG_RESERVE      = 3'd1,
		REG_RESUME       = 3'd2,
		REG_HEADROOM     = 3'd3,
		REG_ALPHA        = 3'd4,
		REG_ACTIVE_PORTS = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  buffer_bytes;
		logic [RSV_W-1:0]   reserve_bytes;
		logic [RSV_W-1:0]   resume_offset_bytes;
		logic [RSV_W-1:0]   headroom_bytes;
		logic [SHIFT_W-1:0] alpha_shift;
		logic [PORTS_W-1:0] active_ports;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] ingress;
		logic [BYTE_W-1:0] headroom;
		logic              paused;
		logic [PKT_W-1:0]  packets;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_THRESH,
		ST_UPDATE,
		ST_USED,
		ST_CHECK_TH,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic clr_write;
		logic load;
		logic mem_read;
		logic calc_used;
		logic calc_th;
		logic su_from_ent;
		logic update;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} status_t;

	function automatic logic [BYTE_W-1:0] sat_byte(input logic [BYTE_W:0] x);
		sat_byte = x[BYTE_W] ? BYTE_MAX : x[BYTE_W-1:0];
	endfunction

endpackage

// ===== design/pfcib_ctrl.sv =====
// Sequencing controller: clear sweep, then one event through read, update and check.
module pfcib_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pfcib_pkg::status_t st,
	output pfcib_pkg::cmd_t    cmd
);

	pfcib_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfcib_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			pfcib_pkg::ST_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (st.clr_last) begin
					state_d = pfcib_pkg::ST_IDLE;
				end
			end
			pfcib_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = pfcib_pkg::ST_READ;
				end
			end
			pfcib_pkg::ST_READ: begin
				cmd.mem_read  = 1'b1;
				cmd.calc_used = 1'b1;
				state_d       = pfcib_pkg::ST_THRESH;
			end
			pfcib_pkg::ST_THRESH: begin
				cmd.calc_th = 1'b1;
				state_d     = pfcib_pkg::ST_UPDATE;
			end
			pfcib_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = pfcib_pkg::ST_USED;
			end
			pfcib_pkg::ST_USED: begin
				cmd.calc_used = 1'b1;
				state_d       = pfcib_pkg::ST_CHECK_TH;
			end
			pfcib_pkg::ST_CHECK_TH: begin
				cmd.calc_th     = 1'b1;
				cmd.su_from_ent = 1'b1;
				state_d         = pfcib_pkg::ST_CHECK;
			end
			pfcib_pkg::ST_CHECK: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = pfcib_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfcib_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== design/pfcib_dp.sv =====
// Datapath: queue table, shared total, threshold unit, update and pause check, result register.
module pfcib_dp #(
	parameter int NUM_PORTS  = 64,
	parameter int NUM_QUEUES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pfcib_pkg::cfg_t                    cfg,
	input  pfcib_pkg::cmd_t                    cmd,
	output pfcib_pkg::status_t                 st,
	input  logic                               req_type,
	input  logic [pfcib_pkg::PORT_W-1:0]       port,
	input  logic [pfcib_pkg::QIDX_W-1:0]       queue_index,
	input  logic [pfcib_pkg::SIZE_W-1:0]       packet_bytes,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               admitted,
	output logic                               send_pause,
	output logic                               send_resume,
	output logic [pfcib_pkg::BYTE_W-1:0]       pfc_threshold,
	output logic [pfcib_pkg::PKT_W-1:0]        queue_packets
);

	localparam int NQ = NUM_PORTS * NUM_QUEUES;
	localparam int AW = (NQ > 1) ? $clog2(NQ) : 1;
	localparam int IW = 14;
	localparam int BW = pfcib_pkg::BYTE_W;

	pfcib_pkg::entry_t mem [NQ];

	logic [AW-1:0]                   clr_idx_q;
	logic                            type_q;
	logic [pfcib_pkg::SIZE_W-1:0]    size_q;
	logic [AW-1:0]                   addr_q;
	logic                            in_range_q;
	pfcib_pkg::entry_t               rd_q;
	pfcib_pkg::entry_t               ent_q;
	logic                            adm_q;
	logic [BW-1:0]                   shared_q;
	logic [pfcib_pkg::SETA_W-1:0]    set_aside_q;
	logic [pfcib_pkg::USED_W-1:0]    used_q;
	logic [BW-1:0]                   th_q;
	logic [BW-1:0]                   su_q;
	logic                            out_valid_q;

	logic [IW-1:0]                   addr_full;
	logic                            in_range;
	logic [pfcib_pkg::RSV_W:0]       hr_res;
	logic [pfcib_pkg::USED_W-1:0]    buf_ext;
	logic [BW-1:0]                   free_b;
	logic [BW-1:0]                   su_src;
	logic [BW-1:0]                   rsv;

	logic [BW:0]                     sz27, hu27, nb, over;
	logic                            drop;
	logic [pfcib_pkg::SIZE_W-1:0]    from_h, rest;
	logic [BW-1:0]                   from_s;
	pfcib_pkg::entry_t               upd;
	logic [BW-1:0]                   sh_new;
	logic                            adm;

	logic                            pause, resume;
	pfcib_pkg::entry_t               ent_new;

	assign addr_full = IW'(port) * IW'(NUM_QUEUES) + IW'(queue_index);
	assign in_range  = (9'(port) < 9'(NUM_PORTS)) && (5'(queue_index) < 5'(NUM_QUEUES));

	assign st.clr_last = (clr_idx_q == AW'(NQ - 1));
	assign st.out_free = !out_valid_q || !out_stall;

	// clear sweep index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_write) begin
			clr_idx_q <= clr_idx_q + AW'(1);
		end
	end

	// queue table
	always_ff @(posedge clk) begin
		if (cmd.clr_write) begin
			mem[clr_idx_q] <= '0;
		end else if (cmd.finish && in_range_q) begin
			mem[addr_q] <= ent_new;
		end
		if (cmd.mem_read) begin
			rd_q <= mem[addr_q];
		end
	end

	// event registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q     <= req_type;
			size_q     <= packet_bytes;
			addr_q     <= addr_full[AW-1:0];
			in_range_q <= in_range;
		end
	end

	// threshold unit: set-aside product, used sum, then free space shifted
	assign hr_res  = {1'b0, cfg.headroom_bytes} + {1'b0, cfg.reserve_bytes};
	assign buf_ext = pfcib_pkg::USED_W'(cfg.buffer_bytes);
	assign free_b  = (buf_ext > used_q) ? BW'(buf_ext - used_q) : '0;
	assign rsv     = BW'(cfg.reserve_bytes);
	assign su_src  = cmd.su_from_ent ? ent_q.ingress : rd_q.ingress;

	always_ff @(posedge clk) begin
		set_aside_q <= pfcib_pkg::SETA_W'(cfg.active_ports) * pfcib_pkg::SETA_W'(hr_res);
		if (cmd.calc_used) begin
			used_q <= pfcib_pkg::USED_W'(set_aside_q) + pfcib_pkg::USED_W'(shared_q);
		end
		if (cmd.calc_th) begin
			th_q <= free_b >> cfg.alpha_shift;
			su_q <= (su_src > rsv) ? su_src - rsv : '0;
		end
	end

	// arrival and departure accounting
	assign sz27 = (BW+1)'(size_q);
	assign hu27 = (BW+1)'(rd_q.headroom);
	assign nb   = (BW+1)'(rd_q.ingress) + sz27;
	assign over = nb - (BW+1)'(rsv);
	assign drop = (sz27 + hu27 > (BW+1)'(cfg.headroom_bytes))
	              && (sz27 + (BW+1)'(su_q) > (BW+1)'(th_q));
	assign from_h = (rd_q.headroom < BW'(size_q)) ? rd_q.headroom[pfcib_pkg::SIZE_W-1:0] : size_q;
	assign rest   = size_q - from_h;
	assign from_s = (BW'(rest) < su_q) ? BW'(rest) : su_q;

	always_comb begin
		upd    = rd_q;
		sh_new = shared_q;
		adm    = 1'b1;
		if (!type_q) begin
			if (drop) begin
				adm = 1'b0;
			end else begin
				if (nb <= (BW+1)'(rsv)) begin
					upd.ingress = pfcib_pkg::sat_byte(nb);
				end else if (over > (BW+1)'(th_q)) begin
					upd.headroom = pfcib_pkg::sat_byte(hu27 + sz27);
				end else begin
					upd.ingress = pfcib_pkg::sat_byte(nb);
					sh_new = pfcib_pkg::sat_byte((BW+1)'(shared_q) + ((sz27 < over) ? sz27 : over));
				end
				if (rd_q.packets != pfcib_pkg::PKT_MAX) begin
					upd.packets = rd_q.packets + pfcib_pkg::PKT_W'(1);
				end
			end
		end else begin
			upd.headroom = rd_q.headroom - BW'(from_h);
			upd.ingress  = (rd_q.ingress > BW'(rest)) ? rd_q.ingress - BW'(rest) : '0;
			sh_new       = (shared_q > from_s) ? shared_q - from_s : '0;
			if (rd_q.packets != '0) begin
				upd.packets = rd_q.packets - pfcib_pkg::PKT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			ent_q <= upd;
			adm_q <= in_range_q ? adm : type_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shared_q <= '0;
		end else if (cmd.update && in_range_q) begin
			shared_q <= sh_new;
		end
	end

	// pause / resume check
	assign pause  = !ent_q.paused && ((ent_q.headroom != '0) || (su_q >= th_q));
	assign resume = ent_q.paused && (ent_q.headroom == '0)
	                && ((su_q == '0)
	                    || ((BW+1)'(su_q) + (BW+1)'(cfg.resume_offset_bytes) <= (BW+1)'(th_q)));

	always_comb begin
		ent_new = ent_q;
		if (pause) begin
			ent_new.paused = 1'b1;
		end else if (resume) begin
			ent_new.paused = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			admitted      <= adm_q;
			send_pause    <= in_range_q && pause;
			send_resume   <= in_range_q && resume;
			pfc_threshold <= th_q;
			queue_packets <= in_range_q ? ent_q.packets : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/pfc_ingress_buffer_admission_top.sv =====
// Top level: configuration registers, controller and datapath.
//
// Ingress buffer accounting with PFC pause/resume for every (port, priority) queue.
// Input channel: one beat per arrival (req_type 0) or departure (req_type 1),
// accepted when in_valid is high and in_stall is low.
// Output channel: one result beat per input beat, in order, held while out_stall is high.
// Config port: cfg_we writes cfg_data into register cfg_index; write only while idle.
// A taken beat passes READ, THRESH, UPDATE, USED, CHECK_TH and CHECK before its result
// shows on out_valid; in_stall stays high until idle, as the single-ported queue table
// and the threshold unit are used once before and once after the update.
// The result register frees the controller: the next beat is taken while a result
// waits, and that event then stalls in its final step until the waiting beat leaves.
// Reset: configuration returns to defaults, then a clear pass writes zero to all
// NUM_PORTS*NUM_QUEUES table entries (512 entries at default size), one per cycle,
// during which in_stall stays high.
module pfc_ingress_buffer_admission_top #(
	parameter int NUM_PORTS  = 64,
	parameter int NUM_QUEUES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pfcib_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [pfcib_pkg::BYTE_W-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               req_type,
	input  logic [pfcib_pkg::PORT_W-1:0]       port,
	input  logic [pfcib_pkg::QIDX_W-1:0]       queue_index,
	input  logic [pfcib_pkg::SIZE_W-1:0]       packet_bytes,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               admitted,
	output logic                               send_pause,
	output logic                               send_resume,
	output logic [pfcib_pkg::BYTE_W-1:0]       pfc_threshold,
	output logic [pfcib_pkg::PKT_W-1:0]        queue_packets
);

	pfcib_pkg::cfg_t    cfg_q;
	pfcib_pkg::cmd_t    cmd;
	pfcib_pkg::status_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_bytes        <= pfcib_pkg::RST_BUFFER;
			cfg_q.reserve_bytes       <= pfcib_pkg::RST_RESERVE;
			cfg_q.resume_offset_bytes <= pfcib_pkg::RST_RESUME;
			cfg_q.headroom_bytes      <= '0;
			cfg_q.alpha_shift         <= '0;
			cfg_q.active_ports        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pfcib_pkg::REG_BUFFER: begin
					cfg_q.buffer_bytes <= cfg_data;
				end
				pfcib_pkg::REG_RESERVE: begin
					cfg_q.reserve_bytes <= cfg_data[pfcib_pkg::RSV_W-1:0];
				end
				pfcib_pkg::REG_RESUME: begin
					cfg_q.resume_offset_bytes <= cfg_data[pfcib_pkg::RSV_W-1:0];
				end
				pfcib_pkg::REG_HEADROOM: begin
					cfg_q.headroom_bytes <= cfg_data[pfcib_pkg::RSV_W-1:0];
				end
				pfcib_pkg::REG_ALPHA: begin
					cfg_q.alpha_shift <= cfg_data[pfcib_pkg::SHIFT_W-1:0];
				end
				pfcib_pkg::REG_ACTIVE_PORTS: begin
					cfg_q.active_ports <= cfg_data[pfcib_pkg::PORTS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	pfcib_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	pfcib_dp #(
		.NUM_PORTS  (NUM_PORTS),
		.NUM_QUEUES (NUM_QUEUES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.st            (st),
		.req_type      (req_type),
		.port          (port),
		.queue_index   (queue_index),
		.packet_bytes  (packet_bytes),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.admitted      (admitted),
		.send_pause    (send_pause),
		.send_resume   (send_resume),
		.pfc_threshold (pfc_threshold),
		.queue_packets (queue_packets)
	);

endmodule

// ===== verif/pfcib_admission_check.sv =====
// Checker for the PFC ingress admission block: mirrors queue accounting and compares result beats.
package pfcib_tb_pkg;

	localparam logic REQ_ARRIVAL   = 1'b0;
	localparam logic REQ_DEPARTURE = 1'b1;
	localparam logic [pfcib_pkg::CIDX_W-1:0] REG_SPARE = 3'd7;

endpackage

module pfcib_admission_check #(
	parameter int NUM_PORTS  = 64,
	parameter int NUM_QUEUES = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pfcib_pkg::CIDX_W-1:0] cfg_index,
	input  logic [pfcib_pkg::BYTE_W-1:0] cfg_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic                         req_type,
	input  logic [pfcib_pkg::PORT_W-1:0] port,
	input  logic [pfcib_pkg::QIDX_W-1:0] queue_index,
	input  logic [pfcib_pkg::SIZE_W-1:0] packet_bytes,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic                         admitted,
	input  logic                         send_pause,
	input  logic                         send_resume,
	input  logic [pfcib_pkg::BYTE_W-1:0] pfc_threshold,
	input  logic [pfcib_pkg::PKT_W-1:0]  queue_packets,
	output int                           mismatches,
	output int                           outstanding,
	output int                           events,
	output int                           drops,
	output int                           pauses,
	output int                           resumes
);
	import pfcib_pkg::*;
	import pfcib_tb_pkg::*;

	localparam int NQ = NUM_PORTS * NUM_QUEUES;
	localparam logic [63:0] BYTE_CAP = {38'd0, BYTE_MAX};

	typedef struct packed {
		logic              admitted;
		logic              send_pause;
		logic              send_resume;
		logic [BYTE_W-1:0] threshold;
		logic [PKT_W-1:0]  packets;
	} verdict_t;

	cfg_t              cfg;
	logic [BYTE_W-1:0] ingress_b  [NQ];
	logic [BYTE_W-1:0] headroom_b [NQ];
	logic              paused_q   [NQ];
	logic [PKT_W-1:0]  pkt_count  [NQ];
	logic [63:0]       shared_total;
	verdict_t          pending_verdicts [$];

	function automatic logic [63:0] sat_bytes(input logic [63:0] x);
		return (x > BYTE_CAP) ? BYTE_CAP : x;
	endfunction

	function automatic logic [63:0] pool_threshold(input logic [63:0] shared);
		logic [63:0] ports_n, per_port, buf_b, used, free_b;
		ports_n  = 64'(cfg.active_ports);
		per_port = 64'(cfg.headroom_bytes);
		per_port = per_port + 64'(cfg.reserve_bytes);
		buf_b    = 64'(cfg.buffer_bytes);
		used     = ports_n * per_port + shared;
		free_b   = (buf_b > used) ? buf_b - used : 64'd0;
		return (free_b >> cfg.alpha_shift) & BYTE_CAP;
	endfunction

	function automatic logic [63:0] shared_of(input int q);
		logic [63:0] ing, rsv;
		ing = 64'(ingress_b[q]);
		rsv = 64'(cfg.reserve_bytes);
		return (ing > rsv) ? ing - rsv : 64'd0;
	endfunction

	task automatic predict_event(
		input  logic              rtype,
		input  logic [PORT_W-1:0] p,
		input  logic [QIDX_W-1:0] qi,
		input  logic [SIZE_W-1:0] sz,
		output verdict_t          v
	);
		int          q;
		logic [63:0] th, su, nb, hu, ing, from_h, rest, from_s, size64, rsv, hr, off;
		size64 = 64'(sz);
		rsv    = 64'(cfg.reserve_bytes);
		hr     = 64'(cfg.headroom_bytes);
		off    = 64'(cfg.resume_offset_bytes);
		v          = '0;
		v.admitted = 1'b1;
		if (int'(p) >= NUM_PORTS || int'(qi) >= NUM_QUEUES) begin
			v.admitted  = (rtype == REQ_DEPARTURE);
			th          = pool_threshold(shared_total);
			v.threshold = th[BYTE_W-1:0];
		end else begin
			q  = int'(p) * NUM_QUEUES + int'(qi);
			hu = 64'(headroom_b[q]);
			if (rtype == REQ_ARRIVAL) begin
				th = pool_threshold(shared_total);
				if (size64 + hu > hr && size64 + shared_of(q) > th) begin
					v.admitted = 1'b0;
				end else begin
					ing = 64'(ingress_b[q]);
					nb  = ing + size64;
					if (nb <= rsv) begin
						ingress_b[q] = BYTE_W'(sat_bytes(nb));
					end else if (nb - rsv > th) begin
						headroom_b[q] = BYTE_W'(sat_bytes(hu + size64));
					end else begin
						ingress_b[q] = BYTE_W'(sat_bytes(nb));
						shared_total = sat_bytes(shared_total +
							((size64 < nb - rsv) ? size64 : nb - rsv));
					end
					if (pkt_count[q] != PKT_MAX)
						pkt_count[q] = pkt_count[q] + 1'b1;
				end
			end else begin
				from_h        = (hu < size64) ? hu : size64;
				rest          = size64 - from_h;
				su            = shared_of(q);
				from_s        = (rest < su) ? rest : su;
				headroom_b[q] = BYTE_W'(hu - from_h);
				ing           = 64'(ingress_b[q]);
				ingress_b[q]  = BYTE_W'((ing > rest) ? ing - rest : 64'd0);
				shared_total  = (shared_total > from_s) ? shared_total - from_s : 64'd0;
				if (pkt_count[q] != '0)
					pkt_count[q] = pkt_count[q] - 1'b1;
			end
			th = pool_threshold(shared_total);
			su = shared_of(q);
			if (!paused_q[q]) begin
				if (headroom_b[q] != '0 || su >= th) begin
					paused_q[q]  = 1'b1;
					v.send_pause = 1'b1;
				end
			end else if (headroom_b[q] == '0 && (su == 64'd0 || su + off <= th)) begin
				paused_q[q]   = 1'b0;
				v.send_resume = 1'b1;
			end
			v.threshold = th[BYTE_W-1:0];
			v.packets   = pkt_count[q];
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t exp_v, got_v;
		if (!arst_n) begin
			cfg.buffer_bytes        = RST_BUFFER;
			cfg.reserve_bytes       = RST_RESERVE;
			cfg.resume_offset_bytes = RST_RESUME;
			cfg.headroom_bytes      = '0;
			cfg.alpha_shift         = '0;
			cfg.active_ports        = '0;
			for (int i = 0; i < NQ; i++) begin
				ingress_b[i]  = '0;
				headroom_b[i] = '0;
				paused_q[i]   = 1'b0;
				pkt_count[i]  = '0;
			end
			shared_total = '0;
			pending_verdicts.delete();
			mismatches  = 0;
			outstanding = 0;
			events      = 0;
			drops       = 0;
			pauses      = 0;
			resumes     = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BUFFER:       cfg.buffer_bytes        = cfg_data;
					REG_RESERVE:      cfg.reserve_bytes       = cfg_data[RSV_W-1:0];
					REG_RESUME:       cfg.resume_offset_bytes = cfg_data[RSV_W-1:0];
					REG_HEADROOM:     cfg.headroom_bytes      = cfg_data[RSV_W-1:0];
					REG_ALPHA:        cfg.alpha_shift         = cfg_data[SHIFT_W-1:0];
					REG_ACTIVE_PORTS: cfg.active_ports        = cfg_data[PORTS_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_event(req_type, port, queue_index, packet_bytes, exp_v);
				pending_verdicts.push_back(exp_v);
			end
			if (out_valid && !out_stall) begin
				got_v = {admitted, send_pause, send_resume, pfc_threshold, queue_packets};
				events++;
				if (!admitted)
					drops++;
				if (send_pause)
					pauses++;
				if (send_resume)
					resumes++;
				if (pending_verdicts.size() == 0) begin
					if (mismatches < 10)
						$display("result beat %0d arrived with no event pending", events);
					mismatches++;
				end else begin
					exp_v = pending_verdicts.pop_front();
					if (got_v !== exp_v) begin
						if (mismatches < 10) begin
							$display("mismatch on beat %0d", events);
							$display("  exp adm=%0b pause=%0b resume=%0b th=%0d pkts=%0d",
								exp_v.admitted, exp_v.send_pause, exp_v.send_resume,
								exp_v.threshold, exp_v.packets);
							$display("  got adm=%0b pause=%0b resume=%0b th=%0d pkts=%0d",
								got_v.admitted, got_v.send_pause, got_v.send_resume,
								got_v.threshold, got_v.packets);
						end
						mismatches++;
					end
				end
			end
			outstanding = pending_verdicts.size();
		end
	end

endmodule

// ===== verif/tb_pfc_ingress_buffer_admission_top.sv =====
// Testbench top for the PFC ingress admission block: clock, reset, stimulus and verdict.
module tb_pfc_ingress_buffer_admission_top;
	import pfcib_pkg::*;
	import pfcib_tb_pkg::*;

	localparam int IDLE_LIMIT = 4000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic              req_type;
	logic [PORT_W-1:0] port;
	logic [QIDX_W-1:0] queue_index;
	logic [SIZE_W-1:0] packet_bytes;
	logic              out_valid;
	logic              out_stall;
	logic              admitted;
	logic              send_pause;
	logic              send_resume;
	logic [BYTE_W-1:0] pfc_threshold;
	logic [PKT_W-1:0]  queue_packets;

	int mismatches, outstanding, events, drops, pauses, resumes;
	int settings_loaded;
	int idle_cycles;
	bit steady;
	bit long_hold_req;

	pfc_ingress_buffer_admission_top i_dut (.*);

	pfcib_admission_check i_check (.*);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = 299;
				out_stall = 1'b1;
			end else begin
				out_stall = !steady && ($urandom_range(99) < 7);
			end
		end
	end

	// leaves in_valid high at the following negedge; caller offers again or settles
	task automatic offer(
		input logic              rt,
		input logic [PORT_W-1:0] p,
		input logic [QIDX_W-1:0] qi,
		input logic [SIZE_W-1:0] sz
	);
		while (!steady && $urandom_range(99) < 7) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		req_type     = rt;
		port         = p;
		queue_index  = qi;
		packet_bytes = sz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic put_reg(
		input logic [CIDX_W-1:0] idx,
		input int                w,
		input logic [BYTE_W-1:0] val
	);
		logic [BYTE_W-1:0] mask, data;
		mask = (26'd1 << w) - 1'b1;
		data = val & mask;
		if ($urandom_range(1))
			data = data | (BYTE_W'($urandom) & ~mask);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
	endtask

	task automatic load_settings(input cfg_t s);
		settle();
		put_reg(REG_SPARE, BYTE_W, BYTE_W'($urandom));
		put_reg(REG_BUFFER, BYTE_W, s.buffer_bytes);
		put_reg(REG_RESERVE, RSV_W, BYTE_W'(s.reserve_bytes));
		put_reg(REG_RESUME, RSV_W, BYTE_W'(s.resume_offset_bytes));
		put_reg(REG_HEADROOM, RSV_W, BYTE_W'(s.headroom_bytes));
		put_reg(REG_ALPHA, SHIFT_W, BYTE_W'(s.alpha_shift));
		put_reg(REG_ACTIVE_PORTS, PORTS_W, BYTE_W'(s.active_ports));
		cfg_we = 1'b0;
		settings_loaded++;
		@(negedge clk);
	endtask

	task automatic random_phase(input int n_items, input bit quiet, input int hold_at);
		cfg_t              s;
		int                hp[4], hq[4];
		int                r, sel, left;
		logic              rt, burst_rt;
		logic [PORT_W-1:0] p;
		logic [QIDX_W-1:0] qi;
		logic [SIZE_W-1:0] sz;
		r = $urandom_range(99);
		s.buffer_bytes = (r < 60) ? BYTE_W'($urandom_range(400000, 20000)) :
			(r < 75) ? BYTE_W'($urandom) : (r < 85) ? BYTE_MAX : (r < 90) ? '0 : RST_BUFFER;
		r = $urandom_range(99);
		s.reserve_bytes = (r < 15) ? '0 : (r < 75) ? RSV_W'($urandom_range(8000, 0)) :
			(r < 90) ? RSV_W'($urandom) : 20'hFFFFF;
		r = $urandom_range(99);
		s.resume_offset_bytes = (r < 85) ? RSV_W'($urandom_range(20000, 0)) :
			(r < 93) ? RSV_W'($urandom) : 20'hFFFFF;
		r = $urandom_range(99);
		s.headroom_bytes = (r < 20) ? '0 : (r < 80) ? RSV_W'($urandom_range(40000, 0)) :
			(r < 90) ? RSV_W'($urandom) : 20'hFFFFF;
		r = $urandom_range(99);
		s.alpha_shift = (r < 80) ? SHIFT_W'($urandom_range(3, 0)) :
			(r < 95) ? SHIFT_W'($urandom) : 5'd31;
		r = $urandom_range(99);
		s.active_ports = (r < 70) ? PORTS_W'($urandom_range(4, 0)) : (r < 80) ? 7'd64 :
			(r < 90) ? 7'd127 : PORTS_W'($urandom);
		load_settings(s);
		for (int k = 0; k < 4; k++) begin
			hp[k] = $urandom_range(63);
			hq[k] = $urandom_range(7);
		end
		steady   = quiet;
		left     = 0;
		sel      = 0;
		burst_rt = REQ_ARRIVAL;
		for (int n = 0; n < n_items; n++) begin
			if (n == hold_at)
				long_hold_req = 1'b1;
			if ($urandom_range(99) < 20) begin
				rt = 1'($urandom_range(1));
				p  = PORT_W'($urandom_range(63));
				qi = QIDX_W'($urandom_range(7));
			end else begin
				if (left == 0) begin
					sel      = $urandom_range(3);
					burst_rt = ($urandom_range(99) < 55) ? REQ_ARRIVAL : REQ_DEPARTURE;
					left     = $urandom_range(12, 1);
				end
				left--;
				rt = burst_rt;
				p  = PORT_W'(hp[sel]);
				qi = QIDX_W'(hq[sel]);
			end
			r  = $urandom_range(99);
			sz = (r < 5) ? 16'h0000 : (r < 10) ? 16'hFFFF :
				(r < 45) ? SIZE_W'($urandom_range(1518, 64)) :
				(r < 75) ? SIZE_W'($urandom_range(9000, 0)) : SIZE_W'($urandom);
			offer(rt, p, qi, sz);
		end
		steady = 1'b0;
	endtask

	initial begin : stimulus
		cfg_t s;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		req_type        = REQ_ARRIVAL;
		port            = '0;
		queue_index     = '0;
		packet_bytes    = '0;
		steady          = 1'b0;
		long_hold_req   = 1'b0;
		settings_loaded = 0;
		idle_cycles     = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		while (in_stall)
			@(negedge clk);

		// reset settings: full-size beats, departure from an empty queue, zero-byte arrival
		offer(REQ_ARRIVAL, 6'd63, 3'd7, 16'hFFFF);
		offer(REQ_DEPARTURE, 6'd63, 3'd7, 16'hFFFF);
		offer(REQ_DEPARTURE, 6'd0, 3'd0, 16'd100);
		offer(REQ_ARRIVAL, 6'd0, 3'd0, 16'd0);

		// small pool: reserve, shared, headroom, drop, then drain to resume
		s.buffer_bytes        = 26'd150000;
		s.reserve_bytes       = 20'd4096;
		s.resume_offset_bytes = 20'd3072;
		s.headroom_bytes      = 20'd70000;
		s.alpha_shift         = 5'd1;
		s.active_ports        = 7'd1;
		load_settings(s);
		offer(REQ_ARRIVAL, 6'd5, 3'd3, 16'd4000);
		repeat (4) offer(REQ_ARRIVAL, 6'd5, 3'd3, 16'd30000);
		offer(REQ_ARRIVAL, 6'd5, 3'd3, 16'd0);
		offer(REQ_DEPARTURE, 6'd5, 3'd3, 16'hFFFF);
		offer(REQ_DEPARTURE, 6'd5, 3'd3, 16'd20000);
		offer(REQ_DEPARTURE, 6'd5, 3'd3, 16'hFFFF);

		// set-aside larger than the buffer
		s.active_ports = 7'd127;
		load_settings(s);
		offer(REQ_ARRIVAL, 6'd5, 3'd3, 16'd100);
		offer(REQ_DEPARTURE, 6'd5, 3'd3, 16'd100);

		s.buffer_bytes        = BYTE_MAX;
		s.reserve_bytes       = 20'hFFFFF;
		s.resume_offset_bytes = 20'hFFFFF;
		s.headroom_bytes      = 20'hFFFFF;
		s.alpha_shift         = 5'd31;
		s.active_ports        = 7'd0;
		load_settings(s);
		offer(REQ_ARRIVAL, 6'd42, 3'd5, 16'hFFFF);
		offer(REQ_DEPARTURE, 6'd42, 3'd5, 16'hFFFF);

		for (int i = 0; i < 8; i++)
			random_phase(250, i == 2, (i == 4) ? 60 : -1);

		settle();
		repeat (20) @(negedge clk);
		$display("run covered %0d events over %0d register settings, with a long output hold",
			events, settings_loaded);
		$display("results seen: %0d dropped, %0d pause, %0d resume", drops, pauses, resumes);
		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
